// ===== rtl/aocf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aocf_pkg: shared types and constants of the accelerometer offset filter
// Field widths, axis slots, board modes, register codes, reset values and the lane control group.
// ----------------------------------------------------------------------------
package aocf_pkg;

   // Field widths.
   localparam int RAW_W   = 8;   // raw two's-complement byte
   localparam int VAL_W   = 7;   // mapped axis count, -32 .. 32
   localparam int OUT_W   = 8;   // result count
   localparam int LIM_W   = 5;   // deadband limit and gravity count
   localparam int MODE_W  = 2;
   localparam int N_AXES  = 3;
   localparam int VAL_MAG = 32;  // largest magnitude of a mapped count

   // Calibration length default.
   localparam int CAL_SAMPLES_DEF = 8;

   // Axis slots.
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int AXIS_Z = 2;

   // Board modes.
   typedef enum logic [MODE_W-1:0] {
      MODE_PLAIN    = 2'd0,
      MODE_SWAP_PRE = 2'd1,
      MODE_CALIB    = 2'd2
   } mode_type;

   // Register map: word index of each control register.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   typedef enum logic [1:0] {
      CSR_BOARD_MODE     = 2'd0,
      CSR_DEADBAND_LIMIT = 2'd1,
      CSR_GRAVITY_COUNTS = 2'd2
   } csr_index_type;

   // Register reset values.
   localparam logic [MODE_W-1:0] BOARD_MODE_RST     = 2'd0;
   localparam logic [LIM_W-1:0]  DEADBAND_LIMIT_RST = 5'd2;
   localparam logic [LIM_W-1:0]  GRAVITY_COUNTS_RST = 5'd16;

   // Per-lane control for one cycle.
   typedef struct packed {
      logic acc_en;   // add the incoming sample to the calibration sum
      logic step_en;  // a calibrated-mode beat leaves the first stage
      logic cal_set;  // that beat is the one that sets the offsets
   } lane_ctrl_type;

endpackage

// ===== rtl/aocf_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aocf_lane: one axis of the offset calibration and smoothing datapath
// Keeps the axis calibration sum, its registered floor mean, the offset and
// the last filtered value, and produces the offset-corrected count.
// ----------------------------------------------------------------------------
module aocf_lane #(
   parameter int CAL_SAMPLES = aocf_pkg::CAL_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  aocf_pkg::lane_ctrl_type              ctrl,
   input  logic signed [aocf_pkg::VAL_W-1:0]    samp_val,
   input  logic signed [aocf_pkg::VAL_W-1:0]    stage_val,
   input  logic        [aocf_pkg::LIM_W-1:0]    grav_counts,
   output logic signed [aocf_pkg::OUT_W-1:0]    corr_val
);

   localparam int VW      = aocf_pkg::VAL_W;
   localparam int OW      = aocf_pkg::OUT_W;
   localparam int BIAS    = aocf_pkg::VAL_MAG * CAL_SAMPLES;
   localparam int SUM_W   = $clog2(BIAS + 1) + 1;
   localparam int BIAS_W  = SUM_W + 1;
   localparam int SHIFT   = BIAS_W + $clog2(CAL_SAMPLES);
   localparam int RECIP   = (2 ** SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES;
   localparam int Q_W     = VW;
   localparam int PROD_W  = SHIFT + Q_W;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [VW-1:0]     mean_ff, mean_in;
   logic signed [VW-1:0]     offset_ff, offset_new;
   logic signed [VW-1:0]     filt_ff, filt_new;
   logic        [BIAS_W-1:0] biased;
   logic        [PROD_W-1:0] prod;
   logic        [Q_W-1:0]    quot;
   logic signed [OW-1:0]     filt_sum, filt_half, mean_adj, offset_cand;

   // Running sum of the calibration samples.
   assign sum_in = ctrl.acc_en
                   ? sum_ff + {{(SUM_W - VW){samp_val[VW-1]}}, samp_val}
                   : sum_ff;

   // Floor mean: bias the sum to non-negative, then multiply by a rounded-up
   // reciprocal. The shift is wide enough that the quotient is exact.
   assign biased = {sum_ff[SUM_W-1], sum_ff} + BIAS_W'(BIAS);
   assign prod   = PROD_W'(biased) * PROD_W'(RECIP);
   assign quot   = prod[SHIFT +: Q_W];
   assign mean_in = $signed(quot - Q_W'(aocf_pkg::VAL_MAG));

   // A zero mean after the gravity count is taken off leaves the previous offset in place.
   assign mean_adj    = {mean_ff[VW-1], mean_ff} - $signed({3'b000, grav_counts});
   assign offset_cand = -mean_adj;
   assign offset_new  = (ctrl.cal_set && (mean_adj != '0)) ? offset_cand[VW-1:0]
                                                           : offset_ff;

   // Average with the last filtered value, rounding toward minus infinity.
   assign filt_sum  = {filt_ff[VW-1], filt_ff} + {stage_val[VW-1], stage_val};
   assign filt_half = filt_sum >>> 1;
   assign filt_new  = filt_half[VW-1:0];

   assign corr_val = {filt_new[VW-1], filt_new} + {offset_new[VW-1], offset_new};

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= '0;
         mean_ff   <= '0;
         offset_ff <= '0;
         filt_ff   <= '0;
      end else begin
         sum_ff  <= sum_in;
         mean_ff <= mean_in;
         if (ctrl.cal_set) begin
            offset_ff <= offset_new;
         end
         if (ctrl.step_en) begin
            filt_ff <= filt_new;
         end
      end
   end

endmodule

// ===== rtl/aocf_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aocf_merge: result merge and output register
// Picks the lane results or the plain mapped counts, deadbands x and y in the
// calibrated mode, and holds the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module aocf_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic                              calib_mode,
   input  logic        [aocf_pkg::LIM_W-1:0] deadband_limit,
   input  logic signed [aocf_pkg::OUT_W-1:0] lane_val [aocf_pkg::N_AXES],
   input  logic signed [aocf_pkg::VAL_W-1:0] plain_val [aocf_pkg::N_AXES],
   input  logic                              rsp_stall,
   output logic                              out_ready,
   output logic                              rsp_valid,
   output logic signed [aocf_pkg::OUT_W-1:0] rsp_accel_x,
   output logic signed [aocf_pkg::OUT_W-1:0] rsp_accel_y,
   output logic signed [aocf_pkg::OUT_W-1:0] rsp_accel_z
);

   localparam int OW = aocf_pkg::OUT_W;
   localparam int VW = aocf_pkg::VAL_W;

   logic                 valid_ff, valid_in;
   logic signed [OW-1:0] res_ff [aocf_pkg::N_AXES];
   logic signed [OW-1:0] res_in [aocf_pkg::N_AXES];
   logic signed [OW:0]   lim_pos, lim_neg;
   logic signed [OW:0]   wide_val [aocf_pkg::N_AXES];

   assign lim_pos = $signed({4'b0000, deadband_limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      for (int i = 0; i < aocf_pkg::N_AXES; i++) begin
         wide_val[i] = {lane_val[i][OW-1], lane_val[i]};
         if (calib_mode) begin
            res_in[i] = lane_val[i];
            if (i != aocf_pkg::AXIS_Z && wide_val[i] <= lim_pos && wide_val[i] >= lim_neg) begin
               res_in[i] = '0;
            end
         end else begin
            res_in[i] = {plain_val[i][VW-1], plain_val[i]};
         end
      end
   end

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_accel_x = res_ff[aocf_pkg::AXIS_X];
   assign rsp_accel_y = res_ff[aocf_pkg::AXIS_Y];
   assign rsp_accel_z = res_ff[aocf_pkg::AXIS_Z];

endmodule

// ===== rtl/accel_offset_calib_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_offset_calib_filter: accelerometer axis mapping, offset calibration
// and smoothing filter with an x/y deadband.
// An accepted request beat is registered in the first stage, then in the merge output register.
// Throughput: one beat per cycle while the response channel does not stall; the pipeline has two
// stages, the first stage and the merge output register.
// Reset (synchronous, active high) clears calibration sums, offsets, filter
// state and pipeline valids, and loads the register reset values.
// ----------------------------------------------------------------------------
module accel_offset_calib_filter #(
   parameter int CAL_SAMPLES = aocf_pkg::CAL_SAMPLES_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [aocf_pkg::RAW_W-1:0]             req_raw_a,
   input  logic [aocf_pkg::RAW_W-1:0]             req_raw_b,
   input  logic [aocf_pkg::RAW_W-1:0]             req_raw_c,
   // Response channel.
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [aocf_pkg::OUT_W-1:0]      rsp_accel_x,
   output logic signed [aocf_pkg::OUT_W-1:0]      rsp_accel_y,
   output logic signed [aocf_pkg::OUT_W-1:0]      rsp_accel_z,
   // Control register port.
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [aocf_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [aocf_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [aocf_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);

   localparam int VW     = aocf_pkg::VAL_W;
   localparam int RW     = aocf_pkg::RAW_W;
   localparam int CNT_W  = $clog2(CAL_SAMPLES + 2);
   localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);

   // ------------------------------------------------------------------------
   // Control registers. Writes land on the access phase; reads are a plain
   // mux of the register values.
   // ------------------------------------------------------------------------
   logic [aocf_pkg::MODE_W-1:0] board_mode_ff;
   logic [aocf_pkg::LIM_W-1:0]  deadband_limit_ff;
   logic [aocf_pkg::LIM_W-1:0]  gravity_counts_ff;
   logic                        csr_wr;
   aocf_pkg::csr_index_type     csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = aocf_pkg::csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         board_mode_ff     <= aocf_pkg::BOARD_MODE_RST;
         deadband_limit_ff <= aocf_pkg::DEADBAND_LIMIT_RST;
         gravity_counts_ff <= aocf_pkg::GRAVITY_COUNTS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            aocf_pkg::CSR_BOARD_MODE: begin
               board_mode_ff <= csr_pwdata[aocf_pkg::MODE_W-1:0];
            end
            aocf_pkg::CSR_DEADBAND_LIMIT: begin
               deadband_limit_ff <= csr_pwdata[aocf_pkg::LIM_W-1:0];
            end
            aocf_pkg::CSR_GRAVITY_COUNTS: begin
               gravity_counts_ff <= csr_pwdata[aocf_pkg::LIM_W-1:0];
            end
            default: begin
               // Unmapped word: the write is dropped.
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         aocf_pkg::CSR_BOARD_MODE: begin
            csr_prdata = {{(aocf_pkg::CSR_DATA_W - aocf_pkg::MODE_W){1'b0}}, board_mode_ff};
         end
         aocf_pkg::CSR_DEADBAND_LIMIT: begin
            csr_prdata = {{(aocf_pkg::CSR_DATA_W - aocf_pkg::LIM_W){1'b0}}, deadband_limit_ff};
         end
         aocf_pkg::CSR_GRAVITY_COUNTS: begin
            csr_prdata = {{(aocf_pkg::CSR_DATA_W - aocf_pkg::LIM_W){1'b0}}, gravity_counts_ff};
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Axis mapping. Each byte is reduced to a 6-bit count by an arithmetic
   // shift of two. Mode 1 negates before the shift (so a count of +32 can
   // appear), mode 2 negates x after the shift; an undefined mode code
   // behaves as the plain mode.
   // ------------------------------------------------------------------------
   logic signed [RW:0]   ext_a, ext_b, ext_c;
   logic signed [RW:0]   shr_a, shr_b, shr_c, shr_nega, shr_negb, neg_shr_b;
   logic signed [VW-1:0] map_val [aocf_pkg::N_AXES];
   logic                 calib_now;

   assign ext_a     = $signed({req_raw_a[RW-1], req_raw_a});
   assign ext_b     = $signed({req_raw_b[RW-1], req_raw_b});
   assign ext_c     = $signed({req_raw_c[RW-1], req_raw_c});
   assign shr_a     = ext_a >>> 2;
   assign shr_b     = ext_b >>> 2;
   assign shr_c     = ext_c >>> 2;
   assign shr_nega  = (-ext_a) >>> 2;
   assign shr_negb  = (-ext_b) >>> 2;
   assign neg_shr_b = -shr_b;
   assign calib_now = (board_mode_ff == aocf_pkg::MODE_CALIB);

   always_comb begin
      map_val[aocf_pkg::AXIS_Z] = shr_c[VW-1:0];
      unique case (board_mode_ff)
         aocf_pkg::MODE_SWAP_PRE: begin
            map_val[aocf_pkg::AXIS_X] = shr_negb[VW-1:0];
            map_val[aocf_pkg::AXIS_Y] = shr_nega[VW-1:0];
         end
         aocf_pkg::MODE_CALIB: begin
            map_val[aocf_pkg::AXIS_X] = neg_shr_b[VW-1:0];
            map_val[aocf_pkg::AXIS_Y] = shr_a[VW-1:0];
         end
         default: begin
            map_val[aocf_pkg::AXIS_X] = shr_a[VW-1:0];
            map_val[aocf_pkg::AXIS_Y] = shr_b[VW-1:0];
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Calibration counter. The first CAL_SAMPLES calibrated-mode beats are
   // summed as they are accepted; the next one sets the offsets and the
   // counter then parks one past CAL_SAMPLES until reset.
   // ------------------------------------------------------------------------
   logic             req_acc;
   logic             out_ready;
   logic             a_move;
   logic             a_vld_ff, a_vld_in;
   logic [CNT_W-1:0] cal_count_ff, cal_count_in;
   logic             acc_now, cal_now;

   assign req_stall = a_vld_ff && !out_ready;
   assign req_acc   = req_valid && !req_stall;
   assign acc_now   = req_acc && calib_now && (cal_count_ff < CAL_LAST);
   assign cal_now   = req_acc && calib_now && (cal_count_ff == CAL_LAST);
   assign cal_count_in = (acc_now || cal_now) ? cal_count_ff + 1'b1 : cal_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_count_ff <= '0;
      end else begin
         cal_count_ff <= cal_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // First pipeline stage: the mapped counts and the beat's flags. The lane
   // means are registered from the sum registers, so they are ready when the
   // offset-setting beat leaves here.
   // ------------------------------------------------------------------------
   logic                 a_calib_ff;
   logic                 a_cal_ff;
   logic signed [VW-1:0] a_val_ff [aocf_pkg::N_AXES];

   assign a_move   = a_vld_ff && out_ready;
   assign a_vld_in = req_acc ? 1'b1 : (a_move ? 1'b0 : a_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         a_val_ff   <= map_val;
         a_calib_ff <= calib_now;
         a_cal_ff   <= cal_now;
      end
   end

   // ------------------------------------------------------------------------
   // Axis lanes. Each lane owns its sum, mean, offset and filter state.
   // ------------------------------------------------------------------------
   aocf_pkg::lane_ctrl_type     lane_ctrl;
   logic signed [aocf_pkg::OUT_W-1:0] lane_val [aocf_pkg::N_AXES];

   assign lane_ctrl.acc_en  = acc_now;
   assign lane_ctrl.step_en = a_move && a_calib_ff;
   assign lane_ctrl.cal_set = a_move && a_calib_ff && a_cal_ff;

   for (genvar g = 0; g < aocf_pkg::N_AXES; g++) begin : g_lane
      aocf_lane #(
         .CAL_SAMPLES (CAL_SAMPLES)
      ) u_lane (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (lane_ctrl),
         .samp_val    (map_val[g]),
         .stage_val   (a_val_ff[g]),
         .grav_counts ((g == aocf_pkg::AXIS_Z) ? gravity_counts_ff : '0),
         .corr_val    (lane_val[g])
      );
   end

   // ------------------------------------------------------------------------
   // Merge stage and output register.
   // ------------------------------------------------------------------------
   aocf_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .load           (a_move),
      .calib_mode     (a_calib_ff),
      .deadband_limit (deadband_limit_ff),
      .lane_val       (lane_val),
      .plain_val      (a_val_ff),
      .rsp_stall      (rsp_stall),
      .out_ready      (out_ready),
      .rsp_valid      (rsp_valid),
      .rsp_accel_x    (rsp_accel_x),
      .rsp_accel_y    (rsp_accel_y),
      .rsp_accel_z    (rsp_accel_z)
   );

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
   // The offset-setting beat in the first stage means the counter has parked.
   a_cal_parked: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && a_cal_ff |-> cal_count_ff == CAL_LAST + 1'b1)
      else $error("calibration beat in flight but counter not parked");

   // A beat in the first stage that cannot move must still be there next cycle.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      a_vld_ff && !a_move |=> a_vld_ff)
      else $error("first-stage beat lost while blocked");

   // Every summed calibration beat advances the counter by exactly one.
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      acc_now |=> cal_count_ff == $past(cal_count_ff) + 1'b1)
      else $error("calibration counter did not advance");

endmodule
